### sv/rsqc_pkg.sv
// ----------------------------------------------------------------------------
// rsqc_pkg
// Shared types and constants for the rotated sprite quad corner unit.
// ----------------------------------------------------------------------------
package rsqc_pkg;

   localparam int COORD_BITS    = 16;
   localparam int ANGLE_BITS    = 12;
   // quarter turn in angle steps; the sine table holds QUARTER+1 entries
   localparam int QUARTER       = 1 << (ANGLE_BITS - 2);
   localparam int ROM_ADDR_BITS = ANGLE_BITS - 1;
   // pi/2 in Q30
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic        [COORD_BITS-1:0] width;
      logic        [COORD_BITS-1:0] height;
      logic        [ANGLE_BITS-1:0] rotation;
      logic                         fixed_orientation;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] corner0_x;
      logic signed [COORD_BITS-1:0] corner0_y;
      logic signed [COORD_BITS-1:0] corner1_x;
      logic signed [COORD_BITS-1:0] corner1_y;
      logic signed [COORD_BITS-1:0] corner2_x;
      logic signed [COORD_BITS-1:0] corner2_y;
      logic signed [COORD_BITS-1:0] corner3_x;
      logic signed [COORD_BITS-1:0] corner3_y;
   } rsp_type;

   // per-stage load enables of the pipeline
   typedef struct packed {
      logic rom;
      logic mult;
      logic offs;
      logic outp;
   } pipe_en_type;

endpackage

### sv/rsqc_sine_rom.sv
// ----------------------------------------------------------------------------
// rsqc_sine_rom
// Quarter-wave sine table with registered reads of sine and cosine.
// ----------------------------------------------------------------------------
module rsqc_sine_rom #(
   parameter int SINE_FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [rsqc_pkg::ANGLE_BITS-1:0]     rotation,
   input  logic                                fixed_orientation,
   output logic signed [SINE_FRAC_BITS+1:0]    sin_val,
   output logic signed [SINE_FRAC_BITS+1:0]    cos_val
);
   import rsqc_pkg::*;

   typedef logic [SINE_FRAC_BITS:0] rom_word_type;
   typedef rom_word_type rom_arr_type [0:QUARTER];

   // unsigned long division for the table build
   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned dvs);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= dvs) begin
            r    = r - dvs;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Table entries from an integer Taylor series in Q30, built at elaboration.
   function automatic rom_arr_type build_rom();
      rom_arr_type       t;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   term;
      longint unsigned   sum;
      longint unsigned   den;
      for (int k = 0; k <= QUARTER; k++) begin
         x    = (64'(k) * HALF_PI_Q30) >> (ANGLE_BITS - 2);
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int n = 1; n < 24; n++) begin
            den  = 64'((2 * n) * (2 * n + 1));
            term = div_u64((term * x2) >> 30, den);
            if (n[0]) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         t[k] = rom_word_type'((sum * (64'd1 << SINE_FRAC_BITS) + (64'd1 << 29)) >> 30);
      end
      t[0]       = '0;
      t[QUARTER] = rom_word_type'(64'd1 << SINE_FRAC_BITS);
      return t;
   endfunction

   localparam rom_arr_type SINE_ROM = build_rom();
   localparam logic [ANGLE_BITS-1:0]    HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
   localparam logic [ANGLE_BITS-1:0]    QTR_ANGLE = ANGLE_BITS'(QUARTER);
   localparam logic [ROM_ADDR_BITS-1:0] QTR_ADDR  = ROM_ADDR_BITS'(QUARTER);

   logic [ANGLE_BITS-1:0]    sin_angle;
   logic [ANGLE_BITS-1:0]    cos_angle;
   logic [ROM_ADDR_BITS-1:0] sin_addr;
   logic [ROM_ADDR_BITS-1:0] cos_addr;
   rom_word_type             sin_mag_ff;
   rom_word_type             cos_mag_ff;
   logic                     sin_neg_ff;
   logic                     cos_neg_ff;

   always_comb begin
      sin_angle = fixed_orientation ? HALF_TURN : rotation;
      cos_angle = sin_angle + QTR_ANGLE;
      // odd quadrants read the table backward
      sin_addr = sin_angle[ANGLE_BITS-2]
               ? QTR_ADDR - {1'b0, sin_angle[ANGLE_BITS-3:0]}
               : {1'b0, sin_angle[ANGLE_BITS-3:0]};
      cos_addr = cos_angle[ANGLE_BITS-2]
               ? QTR_ADDR - {1'b0, cos_angle[ANGLE_BITS-3:0]}
               : {1'b0, cos_angle[ANGLE_BITS-3:0]};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sin_mag_ff <= SINE_ROM[sin_addr];
         cos_mag_ff <= SINE_ROM[cos_addr];
         sin_neg_ff <= sin_angle[ANGLE_BITS-1];
         cos_neg_ff <= cos_angle[ANGLE_BITS-1];
      end
   end

   assign sin_val = sin_neg_ff ? -$signed({1'b0, sin_mag_ff}) : $signed({1'b0, sin_mag_ff});
   assign cos_val = cos_neg_ff ? -$signed({1'b0, cos_mag_ff}) : $signed({1'b0, cos_mag_ff});

endmodule

### sv/rsqc_mult.sv
// ----------------------------------------------------------------------------
// rsqc_mult
// Registered products of sine and cosine with the full width and height.
// ----------------------------------------------------------------------------
module rsqc_mult #(
   parameter int SINE_FRAC_BITS = 14
) (
   input  logic                                                   clock,
   input  logic                                                   enable,
   input  logic signed [SINE_FRAC_BITS+1:0]                       sin_val,
   input  logic signed [SINE_FRAC_BITS+1:0]                       cos_val,
   input  logic        [rsqc_pkg::COORD_BITS-1:0]                 width,
   input  logic        [rsqc_pkg::COORD_BITS-1:0]                 height,
   output logic signed [SINE_FRAC_BITS+rsqc_pkg::COORD_BITS+2:0]  cw_ff,
   output logic signed [SINE_FRAC_BITS+rsqc_pkg::COORD_BITS+2:0]  sh_ff,
   output logic signed [SINE_FRAC_BITS+rsqc_pkg::COORD_BITS+2:0]  ch_ff,
   output logic signed [SINE_FRAC_BITS+rsqc_pkg::COORD_BITS+2:0]  sw_ff
);
   import rsqc_pkg::*;

   logic signed [COORD_BITS:0] w_s;
   logic signed [COORD_BITS:0] h_s;

   assign w_s = $signed({1'b0, width});
   assign h_s = $signed({1'b0, height});

   always_ff @(posedge clock) begin
      if (enable) begin
         cw_ff <= cos_val * w_s;
         sh_ff <= sin_val * h_s;
         ch_ff <= cos_val * h_s;
         sw_ff <= sin_val * w_s;
      end
   end

endmodule

### sv/rsqc_corner.sv
// ----------------------------------------------------------------------------
// rsqc_corner
// Combines the products into rounded corner offsets, adds the center and
// saturates all eight coordinates.
// ----------------------------------------------------------------------------
module rsqc_corner #(
   parameter int SINE_FRAC_BITS = 14
) (
   input  logic                                                   clock,
   input  rsqc_pkg::pipe_en_type                                  en,
   input  logic signed [SINE_FRAC_BITS+rsqc_pkg::COORD_BITS+2:0]  cw,
   input  logic signed [SINE_FRAC_BITS+rsqc_pkg::COORD_BITS+2:0]  sh,
   input  logic signed [SINE_FRAC_BITS+rsqc_pkg::COORD_BITS+2:0]  ch,
   input  logic signed [SINE_FRAC_BITS+rsqc_pkg::COORD_BITS+2:0]  sw,
   input  logic signed [rsqc_pkg::COORD_BITS-1:0]                 center_x,
   input  logic signed [rsqc_pkg::COORD_BITS-1:0]                 center_y,
   output rsqc_pkg::rsp_type                                      rsp_ff
);
   import rsqc_pkg::*;

   localparam int PW = SINE_FRAC_BITS + COORD_BITS + 3;
   localparam int SW = PW + 2;
   localparam int OW = SW - SINE_FRAC_BITS - 1;
   localparam int RW = OW + 1;
   localparam logic signed [SW-1:0] RND    = SW'(64'd1 << SINE_FRAC_BITS);
   localparam logic signed [RW-1:0] SAT_HI = RW'((64'd1 << (COORD_BITS - 1)) - 64'd1);
   localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

   function automatic logic signed [COORD_BITS-1:0] saturate(input logic signed [RW-1:0] v);
      logic signed [COORD_BITS-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[COORD_BITS-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   logic signed [SW-1:0]         cw_e;
   logic signed [SW-1:0]         sh_e;
   logic signed [SW-1:0]         ch_e;
   logic signed [SW-1:0]         sw_e;
   logic signed [SW-1:0]         sum_x [4];
   logic signed [SW-1:0]         sum_y [4];
   logic signed [OW-1:0]         off_x_ff [4];
   logic signed [OW-1:0]         off_y_ff [4];
   logic signed [COORD_BITS-1:0] cx_ff;
   logic signed [COORD_BITS-1:0] cy_ff;
   logic signed [RW-1:0]         pos_x [4];
   logic signed [RW-1:0]         pos_y [4];
   rsp_type                      rsp_in;

   assign cw_e = {{2{cw[PW-1]}}, cw};
   assign sh_e = {{2{sh[PW-1]}}, sh};
   assign ch_e = {{2{ch[PW-1]}}, ch};
   assign sw_e = {{2{sw[PW-1]}}, sw};

   // corner k: bit 0 negates the width offset, bit 1 the height offset
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sum_x[k] = (k[0] ? -cw_e : cw_e) + (k[1] ? -sh_e : sh_e) + RND;
         sum_y[k] = (k[1] ? -ch_e : ch_e) + (k[0] ? sw_e : -sw_e) + RND;
      end
   end

   // arithmetic shift gives the floor; the added half step makes ties go up
   always_ff @(posedge clock) begin
      if (en.offs) begin
         for (int k = 0; k < 4; k++) begin
            off_x_ff[k] <= sum_x[k][SW-1:SINE_FRAC_BITS+1];
            off_y_ff[k] <= sum_y[k][SW-1:SINE_FRAC_BITS+1];
         end
         cx_ff <= center_x;
         cy_ff <= center_y;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pos_x[k] = {{(RW-COORD_BITS){cx_ff[COORD_BITS-1]}}, cx_ff}
                  + {off_x_ff[k][OW-1], off_x_ff[k]};
         pos_y[k] = {{(RW-COORD_BITS){cy_ff[COORD_BITS-1]}}, cy_ff}
                  + {off_y_ff[k][OW-1], off_y_ff[k]};
      end
      rsp_in.corner0_x = saturate(pos_x[0]);
      rsp_in.corner0_y = saturate(pos_y[0]);
      rsp_in.corner1_x = saturate(pos_x[1]);
      rsp_in.corner1_y = saturate(pos_y[1]);
      rsp_in.corner2_x = saturate(pos_x[2]);
      rsp_in.corner2_y = saturate(pos_y[2]);
      rsp_in.corner3_x = saturate(pos_x[3]);
      rsp_in.corner3_y = saturate(pos_y[3]);
   end

   always_ff @(posedge clock) begin
      if (en.outp) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### sv/rotated_sprite_quad_corners_unit.sv
// ----------------------------------------------------------------------------
// rotated_sprite_quad_corners_unit
// Corner vertices of a rotated sprite quad, one sprite per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one sprite beat per cycle unless stalled and returns its four corners
// (Q12.4, rounded to nearest, saturated) through the stages: input
// register, sine/cosine table read, products, rounded offsets, then center
// add and saturation into the result register. The table is a 1025-entry
// quarter wave read for sine and cosine in the same cycle. Each stage has its
// own valid bit, so empty stages fill up while a result sits stalled; the
// input stalls only when all five stages hold a sprite.
module rotated_sprite_quad_corners_unit #(
   parameter int SINE_FRAC_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsqc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsqc_pkg::rsp_type rsp_data
);
   import rsqc_pkg::*;

   localparam int PW = SINE_FRAC_BITS + COORD_BITS + 3;

   pipe_en_type                  en;
   logic                         in_load;
   logic                         in_valid_ff;
   logic                         rom_valid_ff;
   logic                         mult_valid_ff;
   logic                         offs_valid_ff;
   logic                         rsp_valid_ff;
   req_type                      in_ff;
   req_type                      s1_ff;
   logic signed [COORD_BITS-1:0] s2_cx_ff;
   logic signed [COORD_BITS-1:0] s2_cy_ff;
   logic signed [SINE_FRAC_BITS+1:0] sin_val;
   logic signed [SINE_FRAC_BITS+1:0] cos_val;
   logic signed [PW-1:0]         cw;
   logic signed [PW-1:0]         sh;
   logic signed [PW-1:0]         ch;
   logic signed [PW-1:0]         sw;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      en.outp = !rsp_valid_ff || !rsp_stall;
      en.offs = !offs_valid_ff || en.outp;
      en.mult = !mult_valid_ff || en.offs;
      en.rom  = !rom_valid_ff || en.mult;
      in_load = !in_valid_ff || en.rom;
   end

   assign req_stall = !in_load;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rom_valid_ff  <= 1'b0;
         mult_valid_ff <= 1'b0;
         offs_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_valid;
         end
         if (en.rom) begin
            rom_valid_ff <= in_valid_ff;
         end
         if (en.mult) begin
            mult_valid_ff <= rom_valid_ff;
         end
         if (en.offs) begin
            offs_valid_ff <= mult_valid_ff;
         end
         if (en.outp) begin
            rsp_valid_ff <= offs_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_ff <= req_data;
      end
      if (en.rom) begin
         s1_ff <= in_ff;
      end
      if (en.mult) begin
         s2_cx_ff <= s1_ff.center_x;
         s2_cy_ff <= s1_ff.center_y;
      end
   end

   rsqc_sine_rom #(
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_sine_rom (
      .clock             (clock),
      .enable            (en.rom),
      .rotation          (in_ff.rotation),
      .fixed_orientation (in_ff.fixed_orientation),
      .sin_val           (sin_val),
      .cos_val           (cos_val)
   );

   rsqc_mult #(
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_mult (
      .clock   (clock),
      .enable  (en.mult),
      .sin_val (sin_val),
      .cos_val (cos_val),
      .width   (s1_ff.width),
      .height  (s1_ff.height),
      .cw_ff   (cw),
      .sh_ff   (sh),
      .ch_ff   (ch),
      .sw_ff   (sw)
   );

   rsqc_corner #(
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_corner (
      .clock    (clock),
      .en       (en),
      .cw       (cw),
      .sh       (sh),
      .ch       (ch),
      .sw       (sw),
      .center_x (s2_cx_ff),
      .center_y (s2_cy_ff),
      .rsp_ff   (rsp_data)
   );

`ifndef SYNTHESIS
   // a new result only comes from a filled offset stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(offs_valid_ff))
      else $error("result valid without a beat in the offset stage");

   // a stalled result keeps the sprite behind it in place
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && offs_valid_ff) |=> (offs_valid_ff && rsp_valid))
      else $error("beat lost behind a stalled result");

   // the input stalls only with every stage occupied
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rom_valid_ff && mult_valid_ff && offs_valid_ff
                     && rsp_valid_ff))
      else $error("input stalled with an empty stage");
`endif

endmodule
